// ===== hw/rtl/pcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the perspective coordinate map.
// ----------------------------------------------------------------------------
package pcm_pkg;

	localparam int COEF_W     = 48;
	localparam int CRD_W      = 10;
	localparam int NUM_REGS   = 8;
	localparam int IDX_W      = 3;
	localparam int PROD_W     = COEF_W + CRD_W + 1;
	localparam int NUM_W      = PROD_W + 2;
	localparam int ONE_SHIFT  = 32;
	localparam int CLAMP_LOG  = 20;
	localparam int INT_W      = 16;
	localparam int FIDX_W     = 10;

	localparam int DEF_OUT_SIZE  = 1024;
	localparam int DEF_FRAC_BITS = 5;

	localparam logic [IDX_W-1:0] REG_H00 = 3'd0;
	localparam logic [IDX_W-1:0] REG_H01 = 3'd1;
	localparam logic [IDX_W-1:0] REG_H02 = 3'd2;
	localparam logic [IDX_W-1:0] REG_H10 = 3'd3;
	localparam logic [IDX_W-1:0] REG_H11 = 3'd4;
	localparam logic [IDX_W-1:0] REG_H12 = 3'd5;
	localparam logic [IDX_W-1:0] REG_H20 = 3'd6;
	localparam logic [IDX_W-1:0] REG_H21 = 3'd7;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << ONE_SHIFT);

	typedef struct packed {
		logic [CRD_W-1:0] dest_u;
		logic [CRD_W-1:0] dest_v;
	} in_item_t;

	typedef struct packed {
		logic signed [INT_W-1:0] src_x_int;
		logic signed [INT_W-1:0] src_y_int;
		logic [FIDX_W-1:0]       frac_index;
		logic                    coord_valid;
	} out_item_t;

	// Item flags that travel down the pipeline.
	typedef struct packed {
		logic vld;
		logic bad;
	} pcm_ctl_t;

endpackage

// ===== hw/rtl/pcm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_div
// Pipelined restoring divider for both axes over a shared denominator, one
// quotient bit per stage, with clamping and round-to-nearest at the end.
// ----------------------------------------------------------------------------
module pcm_div #(
	parameter int FRAC_BITS = pcm_pkg::DEF_FRAC_BITS,
	parameter int QW        = pcm_pkg::CLAMP_LOG + 2 + FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcm_pkg::pcm_ctl_t             ctl_in,
	input  logic [pcm_pkg::NUM_W-1:0]     an_x,
	input  logic [pcm_pkg::NUM_W-1:0]     an_y,
	input  logic [pcm_pkg::NUM_W-1:0]     ad,
	input  logic                          neg_x,
	input  logic                          neg_y,
	output pcm_pkg::pcm_ctl_t             ctl_out,
	output logic signed [QW:0]            rv_x,
	output logic signed [QW:0]            rv_y
);

	localparam int RW    = pcm_pkg::NUM_W;
	localparam int HI_SH = pcm_pkg::CLAMP_LOG + 1;
	localparam logic [QW-1:0] QTHR =
		QW'(((1 << pcm_pkg::CLAMP_LOG) + 1) << (FRAC_BITS + 1));
	localparam logic [QW-1:0] MAGCLAMP =
		QW'(1 << (pcm_pkg::CLAMP_LOG + FRAC_BITS));

	pcm_pkg::pcm_ctl_t ctl_sd   [0:QW];
	logic [RW-1:0]     ad_sd    [0:QW];
	logic [RW-1:0]     rx_sd    [0:QW];
	logic [RW-1:0]     ry_sd    [0:QW];
	logic [QW-1:0]     lx_sd    [0:QW];
	logic [QW-1:0]     ly_sd    [0:QW];
	logic [QW-1:0]     qx_sd    [0:QW];
	logic [QW-1:0]     qy_sd    [0:QW];
	logic              negx_sd  [0:QW];
	logic              negy_sd  [0:QW];
	logic              ovfx_sd  [0:QW];
	logic              ovfy_sd  [0:QW];

	logic [RW-1:0] hi_x, hi_y;

	assign hi_x = an_x >> HI_SH;
	assign hi_y = an_y >> HI_SH;

	// Setup: a quotient of 2^21 or more is clamped, so the high part of the
	// numerator must stay below the denominator for the bit loop to hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sd[0] <= '0;
		end else begin
			ctl_sd[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		ad_sd[0]   <= ad;
		rx_sd[0]   <= hi_x;
		ry_sd[0]   <= hi_y;
		lx_sd[0]   <= {an_x[HI_SH-1:0], (FRAC_BITS + 1)'(0)};
		ly_sd[0]   <= {an_y[HI_SH-1:0], (FRAC_BITS + 1)'(0)};
		qx_sd[0]   <= '0;
		qy_sd[0]   <= '0;
		negx_sd[0] <= neg_x;
		negy_sd[0] <= neg_y;
		ovfx_sd[0] <= (hi_x >= ad);
		ovfy_sd[0] <= (hi_y >= ad);
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW:0] tx, ty;
		logic        gex, gey;
		logic [RW:0] dx, dy;

		assign tx  = {rx_sd[k], lx_sd[k][QW-1]};
		assign ty  = {ry_sd[k], ly_sd[k][QW-1]};
		assign gex = (tx >= {1'b0, ad_sd[k]});
		assign gey = (ty >= {1'b0, ad_sd[k]});
		assign dx  = tx - {1'b0, ad_sd[k]};
		assign dy  = ty - {1'b0, ad_sd[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sd[k+1] <= '0;
			end else begin
				ctl_sd[k+1] <= ctl_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			ad_sd[k+1]   <= ad_sd[k];
			rx_sd[k+1]   <= gex ? dx[RW-1:0] : tx[RW-1:0];
			ry_sd[k+1]   <= gey ? dy[RW-1:0] : ty[RW-1:0];
			lx_sd[k+1]   <= lx_sd[k] << 1;
			ly_sd[k+1]   <= ly_sd[k] << 1;
			qx_sd[k+1]   <= {qx_sd[k][QW-2:0], gex};
			qy_sd[k+1]   <= {qy_sd[k][QW-2:0], gey};
			negx_sd[k+1] <= negx_sd[k];
			negy_sd[k+1] <= negy_sd[k];
			ovfx_sd[k+1] <= ovfx_sd[k];
			ovfy_sd[k+1] <= ovfy_sd[k];
		end
	end

	// The last quotient bit is the half bit; ties round up for positive
	// results and toward zero magnitude for negative ones.
	logic              clx, cly, incx, incy;
	logic [QW-1:0]     magx, magy;
	logic signed [QW:0] sx, sy;

	always_comb begin
		clx  = ovfx_sd[QW] || (qx_sd[QW] >= QTHR);
		cly  = ovfy_sd[QW] || (qy_sd[QW] >= QTHR);
		incx = qx_sd[QW][0] && (!negx_sd[QW] || (rx_sd[QW] != '0));
		incy = qy_sd[QW][0] && (!negy_sd[QW] || (ry_sd[QW] != '0));
		magx = clx ? MAGCLAMP : (qx_sd[QW] >> 1) + QW'(incx);
		magy = cly ? MAGCLAMP : (qy_sd[QW] >> 1) + QW'(incy);
		sx   = negx_sd[QW] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
		sy   = negy_sd[QW] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_sd[QW];
		end
	end

	always_ff @(posedge clk) begin
		rv_x <= sx;
		rv_y <= sy;
	end

endmodule

// ===== hw/rtl/perspective_coordinate_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_coordinate_map
// Maps each destination pixel through an inverse homography to a rounded
// source coordinate in remap-table format.
// ----------------------------------------------------------------------------
// Usage: an item (dest pixel u, v) is taken on a rising edge with start high.
// busy is always low, so a new item may be started in every cycle and the
// block sustains one item per clock. The result item appears on result for
// exactly one cycle with done high, once the item has passed stages 1 to 3,
// the divider pipeline and the output stage. The divider resolves one
// quotient bit per pipeline stage, most significant first. Results come
// out in the order the items went in. The receiver has no way to stall the
// block; it must take every result in the cycle it is shown.
// The eight matrix coefficients are written over the cfg channel, which is
// always ready; write them only while no item is in flight.
// Reset clears all valid bits of the pipeline and loads the identity matrix.
// A pixel outside the raster or a zero denominator gives an all-zero result
// with coord_valid low.
// ----------------------------------------------------------------------------
module perspective_coordinate_map #(
	parameter int OUT_SIZE  = pcm_pkg::DEF_OUT_SIZE,
	parameter int FRAC_BITS = pcm_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pcm_pkg::in_item_t             dest,
	output logic                          done,
	output pcm_pkg::out_item_t            result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pcm_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pcm_pkg::COEF_W-1:0]    cfg_data
);

	localparam int NW  = pcm_pkg::NUM_W;
	localparam int PW  = pcm_pkg::PROD_W;
	localparam int CW  = pcm_pkg::COEF_W;
	localparam int QW  = pcm_pkg::CLAMP_LOG + 2 + FRAC_BITS;
	localparam int IPW = QW + 1 - FRAC_BITS;
	localparam int LAT = QW + 6;
	localparam logic signed [NW-1:0] ONE_Q = NW'(64'sd1 <<< pcm_pkg::ONE_SHIFT);
	localparam logic signed [IPW-1:0] IP_MAX = IPW'(32'sd32767);
	localparam logic signed [IPW-1:0] IP_MIN = IPW'(-32'sd32768);

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Coefficient registers.
	logic [CW-1:0] coef_q [0:pcm_pkg::NUM_REGS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcm_pkg::NUM_REGS; i++) begin
				coef_q[i] <= (i == int'(pcm_pkg::REG_H00) || i == int'(pcm_pkg::REG_H11)) ?
					pcm_pkg::COEF_ONE : '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// Stage 1: the six products of coefficient and pixel index.
	localparam int CRD_S = pcm_pkg::CRD_W + 1;
	logic signed [CRD_S-1:0] us, vs;
	pcm_pkg::pcm_ctl_t       ctl_s1;
	logic signed [PW-1:0]    pw0_s1, pw1_s1, px0_s1, px1_s1, py0_s1, py1_s1;
	logic                    accept;

	assign accept = start && !busy;
	assign us     = $signed({1'b0, dest.dest_u});
	assign vs     = $signed({1'b0, dest.dest_v});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld <= accept;
			ctl_s1.bad <= (32'(dest.dest_u) >= OUT_SIZE) || (32'(dest.dest_v) >= OUT_SIZE);
		end
	end

	always_ff @(posedge clk) begin
		pw0_s1 <= $signed(coef_q[pcm_pkg::REG_H20]) * us;
		pw1_s1 <= $signed(coef_q[pcm_pkg::REG_H21]) * vs;
		px0_s1 <= $signed(coef_q[pcm_pkg::REG_H00]) * us;
		px1_s1 <= $signed(coef_q[pcm_pkg::REG_H01]) * vs;
		py0_s1 <= $signed(coef_q[pcm_pkg::REG_H10]) * us;
		py1_s1 <= $signed(coef_q[pcm_pkg::REG_H11]) * vs;
	end

	// Stage 2: denominator and both numerators, exact in units of 2^-32.
	pcm_pkg::pcm_ctl_t    ctl_s2;
	logic signed [NW-1:0] w_s2, nx_s2, ny_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s2  <= NW'(pw0_s1) + NW'(pw1_s1) + ONE_Q;
		nx_s2 <= NW'(px0_s1) + NW'(px1_s1) + NW'($signed(coef_q[pcm_pkg::REG_H02]));
		ny_s2 <= NW'(py0_s1) + NW'(py1_s1) + NW'($signed(coef_q[pcm_pkg::REG_H12]));
	end

	// Stage 3: magnitudes and quotient signs; a zero denominator marks the
	// item as invalid.
	pcm_pkg::pcm_ctl_t ctl_s3;
	logic [NW-1:0]     ax_s3, ay_s3, ad_s3;
	logic              negx_s3, negy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3.vld <= ctl_s2.vld;
			ctl_s3.bad <= ctl_s2.bad || (w_s2 == '0);
		end
	end

	always_ff @(posedge clk) begin
		ax_s3   <= nx_s2[NW-1] ? NW'(-nx_s2) : NW'(nx_s2);
		ay_s3   <= ny_s2[NW-1] ? NW'(-ny_s2) : NW'(ny_s2);
		ad_s3   <= w_s2[NW-1] ? NW'(-w_s2) : NW'(w_s2);
		negx_s3 <= nx_s2[NW-1] != w_s2[NW-1];
		negy_s3 <= ny_s2[NW-1] != w_s2[NW-1];
	end

	// Divider pipeline.
	pcm_pkg::pcm_ctl_t   ctl_dv;
	logic signed [QW:0]  rvx, rvy;

	pcm_div #(
		.FRAC_BITS (FRAC_BITS),
		.QW        (QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s3),
		.an_x    (ax_s3),
		.an_y    (ay_s3),
		.ad      (ad_s3),
		.neg_x   (negx_s3),
		.neg_y   (negy_s3),
		.ctl_out (ctl_dv),
		.rv_x    (rvx),
		.rv_y    (rvy)
	);

	// Output stage: floor split, saturation of the integer parts, packing of
	// the fraction index.
	logic signed [IPW-1:0]         ipx, ipy;
	logic [2*FRAC_BITS-1:0]        frc;
	logic signed [pcm_pkg::INT_W-1:0] sat_x, sat_y;
	logic                          done_q;
	pcm_pkg::out_item_t            result_q;

	always_comb begin
		ipx = rvx[QW:FRAC_BITS];
		ipy = rvy[QW:FRAC_BITS];
		frc = {rvy[FRAC_BITS-1:0], rvx[FRAC_BITS-1:0]};
		if (ipx > IP_MAX) begin
			sat_x = pcm_pkg::INT_W'(IP_MAX);
		end else if (ipx < IP_MIN) begin
			sat_x = pcm_pkg::INT_W'(IP_MIN);
		end else begin
			sat_x = pcm_pkg::INT_W'(ipx);
		end
		if (ipy > IP_MAX) begin
			sat_y = pcm_pkg::INT_W'(IP_MAX);
		end else if (ipy < IP_MIN) begin
			sat_y = pcm_pkg::INT_W'(IP_MIN);
		end else begin
			sat_y = pcm_pkg::INT_W'(ipy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_dv.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_dv.bad) begin
			result_q <= '0;
		end else begin
			result_q.src_x_int   <= sat_x;
			result_q.src_y_int   <= sat_y;
			result_q.frac_index  <= pcm_pkg::FIDX_W'(frc);
			result_q.coord_valid <= 1'b1;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	// Every started item comes out after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("item did not complete after the pipeline latency");

	// An invalid coordinate carries all-zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.coord_valid |->
			result.src_x_int == '0 && result.src_y_int == '0 &&
			result.frac_index == '0)
		else $error("invalid coordinate has nonzero fields");

	// A result strobe needs an item that was started in the past.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl_s3.vld, QW + 3))
		else $error("result strobe without an item in flight");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the perspective coordinate map. Destination pixels
// are pushed in bursts under a series of matrix settings; a scoreboard
// predicts every source coordinate and compares it field by field.
// ----------------------------------------------------------------------------

module tb;
	import pcm_pkg::*;

	localparam int FB       = DEF_FRAC_BITS;
	localparam int LATENCY  = FB + 28;
	localparam int LIMIT    = 400000;
	localparam longint ONE  = longint'(1) << ONE_SHIFT;

	// Scoreboard: holds the matrix as the block sees it and the queue of
	// coordinates that are still on their way through the pipeline.
	class coord_scoreboard;
		longint    coef[NUM_REGS];
		out_item_t coords_due[$];
		int        errors;
		int        checked;
		int        invalid_seen;

		function new();
			foreach (coef[i]) coef[i] = 0;
			coef[REG_H00] = ONE;
			coef[REG_H11] = ONE;
			errors = 0;
			checked = 0;
			invalid_seen = 0;
		endfunction

		function void set_coef(int idx, logic [COEF_W-1:0] d);
			coef[idx] = longint'($signed(d));
		endfunction

		// Exact quotient rounded to 1/2^FB, ties toward +infinity.
		function longint round_quot(longint n, longint d);
			bit neg;
			longint unsigned an, ad, q, r;
			neg = (n < 0) != (d < 0);
			an = (n < 0) ? -n : n;
			ad = (d < 0) ? -d : d;
			q = an / ad;
			r = an % ad;
			if (q > (64'd1 << CLAMP_LOG)) begin
				q = 64'd1 << CLAMP_LOG;
				r = 0;
			end
			for (int i = 0; i < FB; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= ad) begin
					r = r - ad;
					q = q | 64'd1;
				end
			end
			if (neg) begin
				if (2 * r > ad) q++;
				return -longint'(q);
			end
			if (2 * r >= ad) q++;
			return longint'(q);
		endfunction

		function void split(longint rv, output logic [INT_W-1:0] ip_o,
				output logic [FB-1:0] fr_o);
			longint ip;
			longint sc;
			sc = longint'(1) << FB;
			if (rv >= 0) ip = rv / sc;
			else ip = -((-rv + sc - 1) / sc);
			fr_o = rv[FB-1:0];
			if (ip > 32767) ip = 32767;
			if (ip < -32768) ip = -32768;
			ip_o = ip[INT_W-1:0];
		endfunction

		function void note_pixel(in_item_t it);
			out_item_t e;
			longint u, v, w, nx, ny;
			logic [FB-1:0] xf, yf;
			e = '0;
			u = longint'(it.dest_u);
			v = longint'(it.dest_v);
			if (u < DEF_OUT_SIZE && v < DEF_OUT_SIZE) begin
				w = coef[REG_H20] * u + coef[REG_H21] * v + ONE;
				if (w != 0) begin
					nx = coef[REG_H00] * u + coef[REG_H01] * v + coef[REG_H02];
					ny = coef[REG_H10] * u + coef[REG_H11] * v + coef[REG_H12];
					split(round_quot(nx, w), e.src_x_int, xf);
					split(round_quot(ny, w), e.src_y_int, yf);
					e.frac_index = FIDX_W'(({yf, xf}));
					e.coord_valid = 1'b1;
				end
			end
			coords_due = {coords_due, e};
		endfunction

		function void check_coord(out_item_t r);
			out_item_t e;
			if (coords_due.size() == 0) begin
				$display("%0t ERROR: unexpected result %p", $time, r);
				errors++;
				return;
			end
			e = coords_due.pop_front();
			checked++;
			if (!e.coord_valid) invalid_seen++;
			if (r.src_x_int !== e.src_x_int) begin
				$display("%0t ERROR src_x_int: expected %0d, actual %0d", $time,
					e.src_x_int, r.src_x_int);
				errors++;
			end
			if (r.src_y_int !== e.src_y_int) begin
				$display("%0t ERROR src_y_int: expected %0d, actual %0d", $time,
					e.src_y_int, r.src_y_int);
				errors++;
			end
			if (r.frac_index !== e.frac_index) begin
				$display("%0t ERROR frac_index: expected %0d, actual %0d", $time,
					e.frac_index, r.frac_index);
				errors++;
			end
			if (r.coord_valid !== e.coord_valid) begin
				$display("%0t ERROR coord_valid: expected %0b, actual %0b", $time,
					e.coord_valid, r.coord_valid);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	in_item_t           dest;
	logic               done;
	out_item_t          result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index;
	logic [COEF_W-1:0]  cfg_data;

	coord_scoreboard sb;
	int unsigned cycles;
	int pixels_sent;
	int settings_used;

	perspective_coordinate_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.dest      (dest),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Acceptance of items and results is observed at the rising edge, where
	// inputs are stable because they only move on the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_pixel(dest);
			if (done) sb.check_coord(result);
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Presents one pixel and holds it until the block takes it. start is left
	// high so that back-to-back items need no extra edge.
	task automatic send_pixel(input logic [CRD_W-1:0] u, input logic [CRD_W-1:0] v);
		bit taken;
		taken = 0;
		start = 1'b1;
		dest.dest_u = u;
		dest.dest_v = v;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
		pixels_sent++;
	endtask

	task automatic idle_cycles(input int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Lets every item in flight come out, then a pipeline's worth more, so
	// that the matrix can be changed safely.
	task automatic drain();
		start = 1'b0;
		while (sb.coords_due.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_coef(input int idx, input logic [COEF_W-1:0] d);
		bit taken;
		taken = 0;
		cfg_valid = 1'b1;
		cfg_index = IDX_W'(idx);
		cfg_data = d;
		while (!taken) begin
			@(posedge clk);
			taken = cfg_ready;
			@(negedge clk);
		end
		cfg_valid = 1'b0;
		sb.set_coef(idx, d);
	endtask

	task automatic load_matrix(input logic [COEF_W-1:0] m[NUM_REGS]);
		drain();
		for (int i = 0; i < NUM_REGS; i++) write_coef(i, m[i]);
		settings_used++;
	endtask

	function automatic logic [COEF_W-1:0] rand_full();
		return {$urandom, $urandom};
	endfunction

	// Signed value of magnitude below 2^(32+shift) in Q16.32.
	function automatic logic [COEF_W-1:0] rand_near(input int shift);
		longint x;
		x = longint'({$urandom, $urandom}) >>> (31 - shift);
		return x[COEF_W-1:0];
	endfunction

	// Builds the matrix of one random phase, by kind.
	function automatic void make_matrix(input int kind, output logic [COEF_W-1:0] m[NUM_REGS]);
		for (int i = 0; i < NUM_REGS; i++) m[i] = '0;
		case (kind)
			0: begin
				m[REG_H00] = rand_near(1);
				m[REG_H01] = rand_near(0);
				m[REG_H02] = rand_near(10);
				m[REG_H10] = rand_near(0);
				m[REG_H11] = rand_near(1);
				m[REG_H12] = rand_near(10);
			end
			1: begin
				for (int i = 0; i < 6; i++) m[i] = rand_near(2);
				m[REG_H20] = rand_near(-11);
				m[REG_H21] = rand_near(-11);
			end
			2: begin
				for (int i = 0; i < NUM_REGS; i++) m[i] = rand_full();
			end
			3: begin
				// w vanishes on a lattice of small pixels.
				for (int i = 0; i < 6; i++) m[i] = rand_near(3);
				m[REG_H20] = -(COEF_W'(64'd1) << (ONE_SHIFT - $urandom_range(0, 2)));
				m[REG_H21] = -(COEF_W'(64'd1) << (ONE_SHIFT - $urandom_range(0, 2)));
			end
			4: begin
				for (int i = 0; i < NUM_REGS; i++) m[i] = {1'b0, {(COEF_W-1){1'b1}}};
			end
			default: begin
				for (int i = 0; i < NUM_REGS; i++) m[i] = {1'b1, {(COEF_W-1){1'b0}}};
			end
		endcase
	endfunction

	initial begin
		logic [COEF_W-1:0] m[NUM_REGS];
		int kind;
		int burst;
		sb = new();
		cycles = 0;
		pixels_sent = 0;
		settings_used = 0;
		arst_n = 1'b0;
		start = 1'b0;
		dest = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: raster corners through the reset identity matrix.
		send_pixel(0, 0);
		send_pixel(CRD_W'(1023), CRD_W'(1023));
		send_pixel(0, CRD_W'(1023));
		send_pixel(CRD_W'(1023), 0);

		// Exact halfway points: positive tie rounds up, negative tie up to zero.
		for (int i = 0; i < NUM_REGS; i++) m[i] = '0;
		m[REG_H00] = COEF_W'(64'd1 << 26);
		m[REG_H11] = -COEF_W'(64'd1 << 26);
		load_matrix(m);
		send_pixel(1, 1);
		send_pixel(3, 3);
		send_pixel(5, 7);

		// Integer saturation at both ends.
		m[REG_H00] = {1'b0, {(COEF_W-1){1'b1}}};
		m[REG_H11] = {1'b1, {(COEF_W-1){1'b0}}};
		load_matrix(m);
		send_pixel(CRD_W'(1023), CRD_W'(1023));
		send_pixel(1, 1);

		// Zero denominator along u = 1, negative one beyond it.
		m[REG_H00] = COEF_W'(ONE);
		m[REG_H11] = COEF_W'(ONE);
		m[REG_H20] = -COEF_W'(ONE);
		load_matrix(m);
		send_pixel(1, 0);
		send_pixel(1, CRD_W'(1023));
		send_pixel(2, 7);
		send_pixel(0, 9);

		// Tiny denominator pushes the quotient into its clamp.
		m[REG_H20] = -COEF_W'(ONE) + COEF_W'(1);
		m[REG_H02] = COEF_W'(ONE);
		m[REG_H12] = -COEF_W'(ONE);
		load_matrix(m);
		send_pixel(1, 0);
		send_pixel(1, 1);

		// Random phases: each loads a fresh matrix, then bursts of pixels.
		for (int ph = 0; ph < 10; ph++) begin
			kind = (ph < 6) ? ph : $urandom_range(0, 3);
			make_matrix(kind, m);
			load_matrix(m);
			for (int n = 0; n < 70; ) begin
				burst = $urandom_range(1, 16);
				for (int b = 0; b < burst; b++) begin
					if (kind == 3 && $urandom_range(0, 1))
						send_pixel(CRD_W'($urandom_range(0, 8)), CRD_W'($urandom_range(0, 8)));
					else
						send_pixel(CRD_W'($urandom), CRD_W'($urandom));
					n++;
				end
				if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
			end
		end

		// Back to identity, then let the pipeline empty.
		for (int i = 0; i < NUM_REGS; i++) m[i] = '0;
		m[REG_H00] = COEF_W'(ONE);
		m[REG_H11] = COEF_W'(ONE);
		load_matrix(m);
		for (int n = 0; n < 20; n++) send_pixel(CRD_W'($urandom), CRD_W'($urandom));
		drain();

		$display("Run covered %0d pixels under %0d matrix settings.", pixels_sent,
			settings_used + 1);
		$display("Checked %0d coordinates, %0d with an undefined denominator.",
			sb.checked, sb.invalid_seen);
		if (sb.errors == 0 && sb.coords_due.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
